// ----- rtl/rlm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlm_pkg : shared types and constants for the rms level meter
// payload structs, fixed constants and the controller/datapath command link
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int SampleBits = 24;
  localparam int MaxBlock   = 4096;
  localparam int SumW       = 58;
  localparam int CntW       = 13;
  localparam int LvlW       = 19;

  localparam logic [SumW-1:0] SumMax     = {SumW{1'b1}};
  localparam logic signed [LvlW-1:0] LvlFloor   = -19'sd255744;
  localparam logic signed [LvlW-1:0] LvlHoldMin = -19'sd15360;
  localparam logic [25:0] DbPerLgQ16 = 26'd50504453;

  localparam logic [0:0] RegBitDepth  = 1'b0;
  localparam logic [0:0] RegDecayStep = 1'b1;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [LvlW-1:0] meter_db;
    logic                   hold_update;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;      // start conversion (totals are latched on the closing sample)
    logic lg_load;    // load log unit with operand
    logic lg_sel;     // 0: sum, 1: count
    logic lg_step;    // one squaring round
    logic lg_save;    // store log result
    logic mul_go;     // form db product
    logic finish;     // apply ballistics and present result
  } rlm_cmd_t;

  typedef struct packed {
    logic zero_sum;
  } rlm_sts_t;

endpackage

// ----- rtl/rlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlm_ctrl : conversion sequencer
// steps the shared log unit over the sum and the count, then the db scaling;
// a zero-sum block goes straight to the finish step
module rlm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  rlm_pkg::rlm_sts_t sts,
  output rlm_pkg::rlm_cmd_t cmd,
  output logic            busy
);
  import rlm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StIter = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StMul2 = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state, state_next;
  logic [3:0] rnd, rnd_next;
  logic       op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rnd   <= '0;
      op    <= 1'b0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    op_next    = op;
    cmd        = '0;
    unique case (state)
      StIdle: begin
        if (go) begin
          cmd.start  = 1'b1;
          op_next    = 1'b0;
          state_next = StLoad;
        end
      end
      StLoad: begin
        if (sts.zero_sum) begin
          state_next = StFin;
        end else begin
          cmd.lg_load = 1'b1;
          cmd.lg_sel  = op;
          rnd_next    = '0;
          state_next  = StIter;
        end
      end
      StIter: begin
        cmd.lg_step = 1'b1;
        rnd_next    = rnd + 4'd1;
        if (rnd == 4'd15) begin
          state_next = StMul;
        end
      end
      StMul: begin
        cmd.lg_save = 1'b1;
        cmd.lg_sel  = op;
        if (!op) begin
          op_next    = 1'b1;
          state_next = StLoad;
        end else begin
          state_next = StMul2;
        end
      end
      StMul2: begin
        cmd.mul_go = 1'b1;
        state_next = StFin;
      end
      StFin: begin
        cmd.finish = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  assign busy = (state != StIdle);

endmodule

// ----- rtl/rlm_dp.sv -----
// ----------------------------------------------------------------------------
// rlm_dp : accumulator, log unit, db scaling and meter ballistics
// squares are accumulated per sample; conversion runs on latched totals
// ----------------------------------------------------------------------------
module rlm_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc_en,
  input  rlm_pkg::in_item_t  in_item,
  input  logic [4:0]         bit_depth,
  input  logic [11:0]        decay_step,
  input  rlm_pkg::rlm_cmd_t  cmd,
  output rlm_pkg::rlm_sts_t  sts,
  output logic               blk_done,
  output rlm_pkg::out_item_t res
);
  import rlm_pkg::*;

  // accumulation
  logic [SumW-1:0] square_sum;
  logic [CntW-1:0] sample_count;
  logic [23:0]     mag;
  logic [47:0]     sq;
  logic [SumW:0]   sum_add;
  logic [SumW-1:0] sum_new;
  logic [CntW-1:0] cnt_new;

  assign mag     = in_item.sample[23] ? 24'(-in_item.sample) : in_item.sample;
  assign sq      = mag * mag;
  assign sum_add = {1'b0, square_sum} + {11'd0, sq};
  assign sum_new = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
  assign cnt_new = sample_count + 13'd1;
  assign blk_done = in_item.block_end || (cnt_new == 13'(MaxBlock));

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (acc_en) begin
      if (blk_done) begin
        square_sum   <= '0;
        sample_count <= '0;
      end else begin
        square_sum   <= sum_new;
        sample_count <= cnt_new;
      end
    end
  end

  // latched block totals
  logic [SumW-1:0] s_blk;
  logic [CntW-1:0] n_blk;
  always_ff @(posedge clk) begin
    if (acc_en && blk_done) begin
      s_blk <= (sum_new < {45'd0, cnt_new}) ? {45'd0, cnt_new} : sum_new;
      n_blk <= cnt_new;
    end
  end

  logic zero_flag;
  always_ff @(posedge clk) begin
    if (acc_en && blk_done) zero_flag <= (sum_new == '0);
  end
  assign sts.zero_sum = zero_flag;

  // log unit: msb index then 16 squaring rounds
  logic [SumW-1:0] lg_op;
  logic [5:0]      msb;
  logic [31:0]     m;
  logic [15:0]     frac;
  logic [5:0]      e;
  logic [63:0]     m_sq;
  logic [33:0]     m_r;
  assign lg_op = cmd.lg_sel ? {45'd0, n_blk} : s_blk;

  always_comb begin
    msb = '0;
    for (int i = 0; i < SumW; i++) begin
      if (lg_op[i]) msb = 6'(i);
    end
  end

  assign m_sq = {32'd0, m} * {32'd0, m};
  assign m_r  = m_sq[63:30] > 34'h0 ? m_sq[63:30] : 34'h0;

  logic [SumW+29:0] norm;
  assign norm = {30'd0, lg_op} << 30 >> msb;

  always_ff @(posedge clk) begin
    if (cmd.lg_load) begin
      m    <= norm[31:0];
      e    <= msb;
      frac <= '0;
    end else if (cmd.lg_step) begin
      if (m_r[31]) begin
        m    <= m_r[32:1];
        frac <= {frac[14:0], 1'b1};
      end else begin
        m    <= m_r[31:0];
        frac <= {frac[14:0], 1'b0};
      end
    end
  end

  logic [21:0] lg_s;
  always_ff @(posedge clk) begin
    if (cmd.lg_save && !cmd.lg_sel) lg_s <= {e, frac};
  end

  // db scaling
  logic [4:0]  d;
  logic [21:0] base;
  logic signed [23:0] x;
  logic [23:0] xmag;
  logic        xneg;
  logic [49:0] prod;
  logic signed [LvlW-1:0] thr;
  logic [49:0] tprod;

  assign d    = (bit_depth < 5'd8) ? 5'd8 :
                (bit_depth > 5'(SampleBits)) ? 5'(SampleBits) : bit_depth;
  assign base = {(6'({1'b0, d}) - 6'd1) << 1, 16'd0};

  always_ff @(posedge clk) begin
    if (cmd.lg_save && cmd.lg_sel) begin
      x <= 24'(signed'({2'b0, lg_s})) - 24'(signed'({2'b0, e, frac}))
           - 24'(signed'({2'b0, base}));
    end
  end

  assign xneg = x[23];
  assign xmag = xneg ? 24'(-x) : x;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= {26'd0, xmag} * {24'd0, DbPerLgQ16};
    end
  end

  // range threshold follows the depth register, also for zero-sum blocks
  always_ff @(posedge clk) begin
    tprod <= {28'd0, base} * {24'd0, DbPerLgQ16};
  end

  logic [49:0] pr, tr;
  logic signed [LvlW-1:0] level;
  logic signed [LvlW-1:0] lvl_pos;
  assign pr  = prod + 50'h80000000;
  assign tr  = tprod + 50'h80000000;
  assign thr = -LvlW'(signed'({1'b0, tr[49:32]}));
  always_comb begin
    lvl_pos = LvlW'(signed'({1'b0, pr[49:32]}));
    if (zero_flag) level = LvlFloor;
    else if (!xneg && pr[49:32] != '0) level = '0;
    else level = -lvl_pos;
  end

  // ballistics
  logic signed [LvlW-1:0] displayed_level, shown;
  logic hold;
  always_comb begin
    shown = displayed_level;
    hold  = 1'b0;
    if (level > displayed_level) begin
      shown = level;
      hold  = (level >= LvlHoldMin);
    end else if (level >= 0) begin
      shown = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      displayed_level <= -19'sd15360;
    end else if (cmd.finish) begin
      if (level < shown) begin
        if (shown > thr) displayed_level <= shown - LvlW'(signed'({1'b0, decay_step}));
        else displayed_level <= LvlFloor;
      end else begin
        displayed_level <= shown;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.meter_db    <= shown;
      res.hold_update <= hold;
    end
  end

endmodule

// ----- rtl/rms_level_meter_db.sv -----
// ----------------------------------------------------------------------------
// rms_level_meter_db : block rms meter in dbfs with fall-back ballistics
// accumulates squared samples, converts each block to 1/256 db steps
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// in       | in_valid/in_ready  | in_item_t (sample, block_end)
// out      | out_valid/out_ready| out_item_t (meter_db, hold_update)
// cfg      | cfg_we             | cfg_index, cfg_data
//
// samples are taken one per cycle while no conversion is running
// a closing sample starts a conversion, which runs the shared log unit
// through 16 squaring rounds for the sum and then for the count before the db
// scaling and out_valid; a zero-sum block skips the log unit
// the result waits in an output register; only a closing sample stalls then
// synchronous active-high reset, no clearing pass
// ----------------------------------------------------------------------------
module rms_level_meter_db (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rlm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data
);
  import rlm_pkg::*;

  logic [4:0]  bit_depth;
  logic [11:0] decay_step;
  rlm_cmd_t    cmd;
  rlm_sts_t    sts;
  logic        busy, blk_done, acc_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth  <= 5'd16;
      decay_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBitDepth:  bit_depth  <= cfg_data[4:0];
        RegDecayStep: decay_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // a pending result blocks the next conversion, so hold off a closing sample
  assign in_ready = !busy && (!out_valid || !blk_done);
  assign acc_en   = in_valid && in_ready;

  rlm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (acc_en && blk_done),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  rlm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .acc_en     (acc_en),
    .in_item    (in_item),
    .bit_depth  (bit_depth),
    .decay_step (decay_step),
    .cmd        (cmd),
    .sts        (sts),
    .blk_done   (blk_done),
    .res        (out_item)
  );

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("sample taken during conversion");
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result lost");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy) else $error("conversion did not start");

endmodule
